### hw/rtl/pli_pkg.sv
// ----------------------------------------------------------------------------
// pli_pkg - shared types and constants of the pilot linear interpolator
// widths, register codes, the front-to-back command and the reciprocal table
// ----------------------------------------------------------------------------
`default_nettype none

package pli_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int MAX_STRIDE   = 16;
  localparam int MAX_TAIL     = 31;

  // configuration register widths
  localparam int LEAD_W       = 4;
  localparam int STRIDE_CFG_W = 5;
  localparam int TAIL_CFG_W   = 5;
  localparam int CFG_DATA_W   = 5;
  localparam int CFG_IDX_W    = 2;

  localparam logic [LEAD_W-1:0]       LEAD_RESET   = LEAD_W'(0);
  localparam logic [STRIDE_CFG_W-1:0] STRIDE_RESET = STRIDE_CFG_W'(2);
  localparam logic [TAIL_CFG_W-1:0]   TAIL_RESET   = TAIL_CFG_W'(0);

  // derived widths
  localparam int STRIDE_W    = $clog2(MAX_STRIDE + 1);
  localparam int TAIL_W      = $clog2(MAX_TAIL + 1);
  localparam int MAG_W       = SAMPLE_WIDTH;
  localparam int DIFF_W      = SAMPLE_WIDTH + 1;
  localparam int REM_W       = STRIDE_W + 1;
  localparam int CNT_A_W     = (TAIL_W > STRIDE_W) ? TAIL_W : STRIDE_W;
  localparam int CNT_W       = (CNT_A_W > LEAD_W) ? CNT_A_W : LEAD_W;
  localparam int RECIP_SHIFT = SAMPLE_WIDTH + $clog2(MAX_STRIDE);
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int PROD_W      = MAG_W + RECIP_W;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEAD_OFFSET  = 2'd0,
    REG_PILOT_STRIDE = 2'd1,
    REG_TAIL_COUNT   = 2'd2
  } cfg_reg_t;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic [MAG_W-1:0]               mag_t;
  typedef logic [STRIDE_W-1:0]            stride_t;
  typedef logic [TAIL_W-1:0]              tail_t;
  typedef logic [LEAD_W-1:0]              lead_t;

  // one classified item, handed from the front to the back
  typedef struct packed {
    logic    first;
    logic    is_final;
    sample_t cur_re;
    sample_t cur_im;
    sample_t prev_re;
    sample_t prev_im;
    logic    neg_re;
    logic    neg_im;
    mag_t    qd_re;
    mag_t    qd_im;
    stride_t rd_re;
    stride_t rd_im;
    stride_t stride;
    lead_t   lead;
    tail_t   tail;
  } cmd_t;

  typedef logic [MAX_STRIDE:0][RECIP_W-1:0] recip_tab_t;

  // ceil(2^RECIP_SHIFT / s) by shift-subtract, evaluated at elaboration
  function automatic recip_tab_t build_recip();
    recip_tab_t tab;
    longint     num;
    longint     rem;
    longint     q;
    tab = '0;
    for (int s = 1; s <= MAX_STRIDE; s++) begin
      num = (longint'(1) << RECIP_SHIFT) + longint'(s) - 1;
      rem = 0;
      q   = 0;
      for (int i = RECIP_W; i >= 0; i--) begin
        rem = (rem << 1) | ((num >> i) & 1);
        q   = q << 1;
        if (rem >= longint'(s)) begin
          rem = rem - longint'(s);
          q   = q | 1;
        end
      end
      tab[s] = RECIP_W'(q);
    end
    return tab;
  endfunction

  localparam recip_tab_t RECIP_TAB = build_recip();

endpackage

`default_nettype wire

### hw/rtl/pilot_linear_interpolator_top.sv
// ----------------------------------------------------------------------------
// pilot_linear_interpolator_top - linear interpolation up-sampler, edge hold
// path: front stages a and b, the queue, the back's command and output registers
// results: lead_offset+1 copies for a first item, stride steps for a later one,
//   plus tail_count copies after a final item; the result sequencer emits one
//   result per cycle while popped and loads each item only once idle
// reset: rst_n synchronous, restores lead_offset=0, pilot_stride=2,
//   tail_count=0, clears the previous sample and starts a new block
// ----------------------------------------------------------------------------
`default_nettype none

module pilot_linear_interpolator_top import pli_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input item channel
  input  wire logic                  in_push,
  input  wire sample_t               in_sample_re,
  input  wire sample_t               in_sample_im,
  input  wire logic                  in_final_sample,
  output logic                       in_full,
  // result channel
  output logic                       out_empty,
  input  wire logic                  out_pop,
  output sample_t                    out_re,
  output sample_t                    out_im,
  output logic                       out_run_last,
  output logic                       out_block_end,
  // configuration write channel
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // front to queue
  logic q_wr;
  cmd_t q_wr_data;
  logic q_full;
  // queue to back
  logic q_rd;
  cmd_t q_rd_data;
  logic q_empty;

  // front: config registers, previous sample, first-of-block flag; a two
  // stage pipe takes the difference to the previous sample, multiplies its
  // magnitude by the stride reciprocal and splits it into quotient and
  // remainder so that the back never divides
  pli_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_sample_re    (in_sample_re),
    .in_sample_im    (in_sample_im),
    .in_final_sample (in_final_sample),
    .in_full         (in_full),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .cfg_ready       (cfg_ready),
    .q_wr            (q_wr),
    .q_wr_data       (q_wr_data),
    .q_full          (q_full)
  );

  // short queue lets the front keep taking items while the back is busy
  pli_cmd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  // back: walks each item out as lead copies or interpolated steps, then the
  // tail copies of a final item; the step accumulator adds quotient and
  // remainder, so rounding to nearest comes out without a divider
  pli_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_rd_data     (q_rd_data),
    .q_empty       (q_empty),
    .q_rd          (q_rd),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_re        (out_re),
    .out_im        (out_im),
    .out_run_last  (out_run_last),
    .out_block_end (out_block_end)
  );

endmodule

`default_nettype wire

### hw/rtl/pli_front.sv
// ----------------------------------------------------------------------------
// pli_front - input side of the pilot linear interpolator
// holds config and previous sample, splits each step into quotient/remainder
// ----------------------------------------------------------------------------
`default_nettype none

module pli_front import pli_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_push,
  input  wire sample_t               in_sample_re,
  input  wire sample_t               in_sample_im,
  input  wire logic                  in_final_sample,
  output logic                       in_full,
  input  wire logic                  cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic                       cfg_ready,
  output logic                       q_wr,
  output cmd_t                       q_wr_data,
  input  wire logic                  q_full
);

  localparam int RDP_W = MAG_W + STRIDE_W;

  logic [LEAD_W-1:0]       lead_r;
  logic [STRIDE_CFG_W-1:0] stride_cfg_r;
  logic [TAIL_CFG_W-1:0]   tail_cfg_r;
  sample_t                 prev_re_r, prev_im_r;
  logic                    awaiting_r;

  logic                    a_v_r, b_v_r;
  cmd_t                    a_cmd_r, b_cmd_r;
  mag_t                    a_mag_re_r, a_mag_im_r, b_mag_re_r, b_mag_im_r;
  logic [PROD_W-1:0]       b_prod_re_r, b_prod_im_r;

  logic                    accept, a_adv, b_adv;
  logic signed [DIFF_W-1:0] diff_re, diff_im;
  stride_t                 stride_eff;
  tail_t                   tail_eff;
  cmd_t                    a_cmd_nxt;
  mag_t                    qd_re, qd_im;
  logic [RDP_W-1:0]        rdp_re, rdp_im;

  assign cfg_ready = 1'b1;

  // stage handshake: a stage moves when it is empty or the stage after it can drain
  assign b_adv   = !b_v_r || !q_full;
  assign a_adv   = !a_v_r || b_adv;
  assign in_full = !a_adv;
  assign accept  = in_push && a_adv;

  always_comb begin
    if (stride_cfg_r == '0) begin
      stride_eff = STRIDE_W'(1);
    end else if (int'(stride_cfg_r) > MAX_STRIDE) begin
      stride_eff = STRIDE_W'(MAX_STRIDE);
    end else begin
      stride_eff = STRIDE_W'(stride_cfg_r);
    end
    if (int'(tail_cfg_r) > MAX_TAIL) begin
      tail_eff = TAIL_W'(MAX_TAIL);
    end else begin
      tail_eff = TAIL_W'(tail_cfg_r);
    end
  end

  assign diff_re = DIFF_W'(in_sample_re) - DIFF_W'(prev_re_r);
  assign diff_im = DIFF_W'(in_sample_im) - DIFF_W'(prev_im_r);

  always_comb begin
    a_cmd_nxt          = '0;
    a_cmd_nxt.first    = awaiting_r;
    a_cmd_nxt.is_final = in_final_sample;
    a_cmd_nxt.cur_re   = in_sample_re;
    a_cmd_nxt.cur_im   = in_sample_im;
    a_cmd_nxt.prev_re  = prev_re_r;
    a_cmd_nxt.prev_im  = prev_im_r;
    a_cmd_nxt.neg_re   = diff_re[DIFF_W-1];
    a_cmd_nxt.neg_im   = diff_im[DIFF_W-1];
    a_cmd_nxt.stride   = stride_eff;
    a_cmd_nxt.lead     = lead_r;
    a_cmd_nxt.tail     = tail_eff;
  end

  // quotient from the registered product, remainder by one narrow multiply
  assign qd_re  = b_prod_re_r[RECIP_SHIFT +: MAG_W];
  assign qd_im  = b_prod_im_r[RECIP_SHIFT +: MAG_W];
  assign rdp_re = RDP_W'(b_mag_re_r) - RDP_W'(qd_re) * RDP_W'(b_cmd_r.stride);
  assign rdp_im = RDP_W'(b_mag_im_r) - RDP_W'(qd_im) * RDP_W'(b_cmd_r.stride);

  always_comb begin
    q_wr_data       = b_cmd_r;
    q_wr_data.qd_re = qd_re;
    q_wr_data.qd_im = qd_im;
    q_wr_data.rd_re = rdp_re[STRIDE_W-1:0];
    q_wr_data.rd_im = rdp_im[STRIDE_W-1:0];
  end
  assign q_wr = b_v_r && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r       <= LEAD_RESET;
      stride_cfg_r <= STRIDE_RESET;
      tail_cfg_r   <= TAIL_RESET;
      prev_re_r    <= '0;
      prev_im_r    <= '0;
      awaiting_r   <= 1'b1;
      a_v_r        <= 1'b0;
      b_v_r        <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_LEAD_OFFSET:  lead_r       <= cfg_data[LEAD_W-1:0];
          REG_PILOT_STRIDE: stride_cfg_r <= cfg_data[STRIDE_CFG_W-1:0];
          REG_TAIL_COUNT:   tail_cfg_r   <= cfg_data[TAIL_CFG_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        prev_re_r  <= in_sample_re;
        prev_im_r  <= in_sample_im;
        awaiting_r <= in_final_sample;
      end
      if (a_adv) begin
        a_v_r <= in_push;
      end
      if (b_adv) begin
        b_v_r <= a_v_r;
      end
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (a_adv) begin
      a_cmd_r    <= a_cmd_nxt;
      a_mag_re_r <= diff_re[DIFF_W-1] ? MAG_W'(-diff_re) : MAG_W'(diff_re);
      a_mag_im_r <= diff_im[DIFF_W-1] ? MAG_W'(-diff_im) : MAG_W'(diff_im);
    end
    if (b_adv) begin
      b_cmd_r     <= a_cmd_r;
      b_mag_re_r  <= a_mag_re_r;
      b_mag_im_r  <= a_mag_im_r;
      b_prod_re_r <= PROD_W'(a_mag_re_r) * PROD_W'(RECIP_TAB[a_cmd_r.stride]);
      b_prod_im_r <= PROD_W'(a_mag_im_r) * PROD_W'(RECIP_TAB[a_cmd_r.stride]);
    end
  end

`ifndef NO_ASSERTIONS
  // reciprocal split must be exact: remainder below the stride
  a_rem_exact: assert property (@(posedge clk) disable iff (!rst_n)
    q_wr |-> (q_wr_data.rd_re < q_wr_data.stride) && (q_wr_data.rd_im < q_wr_data.stride))
    else $error("front remainder not below stride");
  // an item marked final makes the next one start a new block
  a_block_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_final_sample) |=> awaiting_r)
    else $error("block restart flag not set after final item");
`endif

endmodule

`default_nettype wire

### hw/rtl/pli_cmd_queue.sv
// ----------------------------------------------------------------------------
// pli_cmd_queue - short command queue between front and back
// four entries (QUEUE_DEPTH) of cmd_t with read and write pointers and a fill count
// ----------------------------------------------------------------------------
`default_nettype none

module pli_cmd_queue import pli_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_en,
  input  wire cmd_t wr_data,
  output logic      full,
  input  wire logic rd_en,
  output cmd_t      rd_data,
  output logic      empty
);

  cmd_t              entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r;
  logic              do_wr, do_rd;

  assign full    = count_r == (QPTR_W + 1)'(QUEUE_DEPTH);
  assign empty   = count_r == '0;
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + (QPTR_W + 1)'(1);
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - (QPTR_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entry_r[wr_ptr_r] <= wr_data;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (QPTR_W + 1)'(QUEUE_DEPTH))
    else $error("queue count out of range");
  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != (QPTR_W + 1)'(QUEUE_DEPTH)) |-> (QPTR_W'(rd_ptr_r + count_r[QPTR_W-1:0]) == wr_ptr_r))
    else $error("queue pointers disagree with count");
`endif

endmodule

`default_nettype wire

### hw/rtl/pli_back.sv
// ----------------------------------------------------------------------------
// pli_back - result sequencer of the pilot linear interpolator
// emits lead copies, interpolated steps and tail copies, one per cycle while popped, idle to load each item
// ----------------------------------------------------------------------------
`default_nettype none

module pli_back import pli_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cmd_t q_rd_data,
  input  wire logic q_empty,
  output logic      q_rd,
  output logic      out_empty,
  input  wire logic out_pop,
  output sample_t   out_re,
  output sample_t   out_im,
  output logic      out_run_last,
  output logic      out_block_end
);

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_MAIN = 3'b010,
    PH_TAIL = 3'b100
  } phase_t;

  phase_t              phase_r, phase_nxt;
  cmd_t                cmd_r;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt, main_end_r;
  mag_t                acc_re_r, acc_im_r, acc_re_nxt, acc_im_nxt;
  stride_t             rem_re_r, rem_im_r, rem_re_nxt, rem_im_nxt;
  logic                out_v_r;
  sample_t             out_re_r, out_im_r;
  logic                out_run_last_r, out_block_end_r;

  logic                adv, emit, main_last, tail_last, has_tail, run_last;
  logic [REM_W-1:0]    rsum_re, rsum_im;
  logic                wrap_re, wrap_im;
  logic signed [DIFF_W-1:0] ival_re, ival_im;
  sample_t             val_re, val_im;

  assign adv       = !out_v_r || out_pop;
  assign emit      = (phase_r != PH_IDLE) && adv;
  assign q_rd      = (phase_r == PH_IDLE) && !q_empty;
  assign has_tail  = cmd_r.is_final && (cmd_r.tail != '0);
  assign main_last = cnt_r == main_end_r;
  assign tail_last = cnt_r == CNT_W'(cmd_r.tail - TAIL_W'(1));

  // next step: remainder wraps at most once per step
  assign rsum_re    = REM_W'(rem_re_r) + REM_W'(cmd_r.rd_re);
  assign rsum_im    = REM_W'(rem_im_r) + REM_W'(cmd_r.rd_im);
  assign wrap_re    = rsum_re >= REM_W'(cmd_r.stride);
  assign wrap_im    = rsum_im >= REM_W'(cmd_r.stride);
  assign rem_re_nxt = wrap_re ? STRIDE_W'(rsum_re - REM_W'(cmd_r.stride)) : STRIDE_W'(rsum_re);
  assign rem_im_nxt = wrap_im ? STRIDE_W'(rsum_im - REM_W'(cmd_r.stride)) : STRIDE_W'(rsum_im);
  assign acc_re_nxt = acc_re_r + cmd_r.qd_re + MAG_W'(wrap_re);
  assign acc_im_nxt = acc_im_r + cmd_r.qd_im + MAG_W'(wrap_im);

  assign ival_re = cmd_r.neg_re ? DIFF_W'(cmd_r.prev_re) - $signed({1'b0, acc_re_nxt})
                                : DIFF_W'(cmd_r.prev_re) + $signed({1'b0, acc_re_nxt});
  assign ival_im = cmd_r.neg_im ? DIFF_W'(cmd_r.prev_im) - $signed({1'b0, acc_im_nxt})
                                : DIFF_W'(cmd_r.prev_im) + $signed({1'b0, acc_im_nxt});

  always_comb begin
    if (phase_r == PH_MAIN && !cmd_r.first) begin
      val_re = ival_re[SAMPLE_WIDTH-1:0];
      val_im = ival_im[SAMPLE_WIDTH-1:0];
    end else begin
      val_re = cmd_r.cur_re;
      val_im = cmd_r.cur_im;
    end
    if (phase_r == PH_TAIL) begin
      run_last = tail_last;
    end else begin
      run_last = main_last && !has_tail;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    case (phase_r)
      PH_IDLE: begin
        if (!q_empty) begin
          phase_nxt = PH_MAIN;
          cnt_nxt   = '0;
        end
      end
      PH_MAIN: begin
        if (adv) begin
          cnt_nxt = cnt_r + CNT_W'(1);
          if (main_last) begin
            cnt_nxt   = '0;
            phase_nxt = has_tail ? PH_TAIL : PH_IDLE;
          end
        end
      end
      PH_TAIL: begin
        if (adv) begin
          cnt_nxt = cnt_r + CNT_W'(1);
          if (tail_last) begin
            phase_nxt = PH_IDLE;
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      if (emit) begin
        out_v_r <= 1'b1;
      end else if (out_pop) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      cmd_r      <= q_rd_data;
      main_end_r <= q_rd_data.first ? CNT_W'(q_rd_data.lead)
                                    : CNT_W'(q_rd_data.stride - STRIDE_W'(1));
      acc_re_r   <= '0;
      acc_im_r   <= '0;
      rem_re_r   <= q_rd_data.stride >> 1;
      rem_im_r   <= q_rd_data.stride >> 1;
    end else if (emit && phase_r == PH_MAIN) begin
      acc_re_r <= acc_re_nxt;
      acc_im_r <= acc_im_nxt;
      rem_re_r <= rem_re_nxt;
      rem_im_r <= rem_im_nxt;
    end
    if (emit) begin
      out_re_r        <= val_re;
      out_im_r        <= val_im;
      out_run_last_r  <= run_last;
      out_block_end_r <= run_last && cmd_r.is_final;
    end
  end

  assign out_empty     = !out_v_r;
  assign out_re        = out_re_r;
  assign out_im        = out_im_r;
  assign out_run_last  = out_run_last_r;
  assign out_block_end = out_block_end_r;

`ifndef NO_ASSERTIONS
  a_tail_final: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_TAIL) |-> cmd_r.is_final)
    else $error("tail phase on an item not marked final");
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_MAIN && !cmd_r.first) |-> (rem_re_r < cmd_r.stride && rem_im_r < cmd_r.stride))
    else $error("interpolation remainder out of range");
  a_lands_on_sample: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && phase_r == PH_MAIN && !cmd_r.first && main_last)
      |-> (val_re == cmd_r.cur_re && val_im == cmd_r.cur_im))
    else $error("last interpolated step differs from the sample");
`endif

endmodule

`default_nettype wire

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - testbench of the pilot linear interpolator
// drives known and random samples into the input queue, rewrites the three registers
// between phases and checks every result against an in-bench interpolator
// model, with random gaps on the input side and random stalls on the result side
// ----------------------------------------------------------------------------
module tb_top;
  import pli_pkg::*;

  // index with no register behind it, writes to it change nothing
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  // cycles to let pass once the last result is in (block latency plus margin)
  localparam int SETTLE_CYCLES = 12;

  typedef struct packed {
    sample_t re;
    sample_t im;
    logic    run_last;
    logic    block_end;
  } interp_out_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_push;
  sample_t               in_sample_re;
  sample_t               in_sample_im;
  logic                  in_final_sample;
  logic                  in_full;
  logic                  out_empty;
  logic                  out_pop;
  sample_t               out_re;
  sample_t               out_im;
  logic                  out_run_last;
  logic                  out_block_end;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pilot_linear_interpolator_top u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_sample_re    (in_sample_re),
    .in_sample_im    (in_sample_im),
    .in_final_sample (in_final_sample),
    .in_full         (in_full),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_re          (out_re),
    .out_im          (out_im),
    .out_run_last    (out_run_last),
    .out_block_end   (out_block_end),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // model copy of the registers and of the running state
  logic [LEAD_W-1:0]       lead_cfg;
  logic [STRIDE_CFG_W-1:0] stride_cfg;
  logic [TAIL_CFG_W-1:0]   tail_cfg;
  sample_t                 prv_re;
  sample_t                 prv_im;
  logic                    need_first;

  // samples the block still owes us, oldest first
  interp_out_t pending_out[$];

  int  mismatch_cnt;
  int  fail_cnt;
  bit  idle_en;
  int  pop_stall;

  // ---------------------------------------------------------------- clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------- model
  // point k of s between a and b, rounded to nearest with ties away from zero
  function automatic sample_t lerp_point(sample_t a, sample_t b, int k, int s);
    longint num;
    longint mag;
    longint q;
    num = longint'(k) * (longint'(b) - longint'(a));
    mag = (num < 0) ? -num : num;
    q   = (mag + longint'(s / 2)) / longint'(s);
    if (num < 0) q = -q;
    return sample_t'(longint'(a) + q);
  endfunction

  // work out every sample that one accepted item causes
  function automatic void interp_predict(sample_t cur_re, sample_t cur_im, logic fin);
    int          stride;
    int          tail;
    int          head;
    int          total;
    interp_out_t r;
    // zero stride acts as one, oversized stride clips to the maximum
    stride = (stride_cfg == 0) ? 1 : int'(stride_cfg);
    if (stride > MAX_STRIDE) stride = MAX_STRIDE;
    tail = (int'(tail_cfg) > MAX_TAIL) ? MAX_TAIL : int'(tail_cfg);
    head = need_first ? int'(lead_cfg) + 1 : stride;
    total = head + (fin ? tail : 0);
    for (int i = 0; i < total; i++) begin
      if (i >= head) begin
        // tail copies hold the final sample
        r.re = cur_re;
        r.im = cur_im;
      end else if (need_first) begin
        // lead copies hold the first sample
        r.re = cur_re;
        r.im = cur_im;
      end else begin
        r.re = lerp_point(prv_re, cur_re, i + 1, stride);
        r.im = lerp_point(prv_im, cur_im, i + 1, stride);
      end
      r.run_last  = (i == total - 1);
      r.block_end = (i == total - 1) && fin;
      pending_out.push_back(r);
    end
    prv_re     = cur_re;
    prv_im     = cur_im;
    need_first = fin;
  endfunction

  // ---------------------------------------------------------------- result side
  // pop stalls in bursts of random length while idling is on
  always @(negedge clk) begin
    if (pop_stall > 0) begin
      pop_stall <= pop_stall - 1;
      out_pop   <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      pop_stall <= $urandom_range(0, 2);
      out_pop   <= 1'b0;
    end else begin
      out_pop <= 1'b1;
    end
  end

  // compare each popped sample with the oldest one owed
  always @(posedge clk) begin : chk
    interp_out_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_out.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("unexpected result re=%0d im=%0d last=%b end=%b", out_re, out_im,
                   out_run_last, out_block_end);
      end else begin
        want = pending_out.pop_front();
        if (out_re !== want.re || out_im !== want.im || out_run_last !== want.run_last ||
            out_block_end !== want.block_end) begin
          mismatch_cnt++;
          fail_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: exp re=%0d im=%0d last=%b end=%b, got re=%0d im=%0d last=%b end=%b",
                     want.re, want.im, want.run_last, want.block_end,
                     out_re, out_im, out_run_last, out_block_end);
        end
      end
    end
  end

  // ---------------------------------------------------------------- input side
  // push one known sample, with an occasional gap before it
  task automatic send_item(sample_t re, sample_t im, logic fin);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        @(negedge clk);
        in_push <= 1'b0;
      end
    end
    @(negedge clk);
    in_push         <= 1'b1;
    in_sample_re    <= re;
    in_sample_im    <= im;
    in_final_sample <= fin;
    do @(posedge clk); while (in_full);
    interp_predict(re, im, fin);
  endtask

  // stop pushing and wait until the block has handed out everything owed
  task automatic settle();
    @(negedge clk);
    in_push <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write, only called while the block is idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_LEAD_OFFSET:  lead_cfg   = data[LEAD_W-1:0];
      REG_PILOT_STRIDE: stride_cfg = data;
      REG_TAIL_COUNT:   tail_cfg   = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // random sample with extra weight on the range ends and on tiny values
  function automatic sample_t rand_sample();
    case ($urandom_range(0, 7))
      0:       return sample_t'(16'h7fff);
      1:       return sample_t'(16'h8000);
      2:       return sample_t'($signed($urandom_range(0, 6)) - 3);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------- tests
  // reset values: no lead, stride two, no tail
  task automatic test_reset_config();
    send_item(sample_t'(16'h7fff), sample_t'(16'h8000), 1'b0);
    // full-scale swing, half steps round away from zero
    send_item(sample_t'(16'h8000), sample_t'(16'h7fff), 1'b0);
    send_item(sample_t'(0), sample_t'(-1), 1'b0);
    send_item(sample_t'(-1), sample_t'(0), 1'b1);
    // first sample that is also final, no tail
    send_item(sample_t'(1), sample_t'(-1), 1'b1);
  endtask

  // longest lead, stride and tail
  task automatic test_long_lead_tail();
    settle();
    write_reg(REG_LEAD_OFFSET, 5'h1f);   // top data bit is dropped
    write_reg(REG_PILOT_STRIDE, 5'd16);
    write_reg(REG_TAIL_COUNT, 5'd31);
    // final first sample: lead copies run straight into the tail
    send_item(sample_t'(16'h8000), sample_t'(16'h7fff), 1'b1);
    send_item(sample_t'(100), sample_t'(-100), 1'b0);
    send_item(sample_t'(16'h8000), sample_t'(16'h7fff), 1'b0);
    send_item(sample_t'(16'h7fff), sample_t'(16'h8000), 1'b1);
  endtask

  // stride zero, stride past the maximum, stride one, odd stride
  task automatic test_stride_limits();
    settle();
    write_reg(REG_LEAD_OFFSET, 5'd0);
    write_reg(REG_TAIL_COUNT, 5'd1);
    write_reg(REG_PILOT_STRIDE, 5'd0);
    send_item(sample_t'(5), sample_t'(-5), 1'b0);
    send_item(sample_t'(-7), sample_t'(9), 1'b1);
    settle();
    write_reg(REG_PILOT_STRIDE, 5'd31);
    send_item(sample_t'(-3), sample_t'(3), 1'b0);
    send_item(sample_t'(16'h7fff), sample_t'(16'h8000), 1'b1);
    settle();
    write_reg(REG_PILOT_STRIDE, 5'd17);
    send_item(sample_t'(0), sample_t'(0), 1'b0);
    send_item(sample_t'(-24), sample_t'(24), 1'b1);
    settle();
    write_reg(REG_PILOT_STRIDE, 5'd1);
    send_item(sample_t'(1234), sample_t'(-4321), 1'b0);
    send_item(sample_t'(-1), sample_t'(1), 1'b1);
    settle();
    write_reg(REG_PILOT_STRIDE, 5'd3);
    send_item(sample_t'(0), sample_t'(0), 1'b0);
    send_item(sample_t'(-5), sample_t'(4), 1'b1);
  endtask

  // a write to the spare index must leave the settings alone
  task automatic test_unused_index();
    settle();
    write_reg(REG_UNUSED, 5'h1f);
    send_item(sample_t'(300), sample_t'(-300), 1'b0);
    send_item(sample_t'(-301), sample_t'(299), 1'b1);
  endtask

  // random settings per phase, random blocks of random samples
  task automatic test_random_blocks();
    logic [CFG_DATA_W-1:0] d;
    for (int ph = 0; ph < 8; ph++) begin
      settle();
      // one phase without gaps early on, none at all in the last part
      idle_en = (ph != 2) && (ph < 6);
      case ($urandom_range(0, 3))
        0:       d = 5'd0;
        1:       d = 5'd15;
        2:       d = CFG_DATA_W'($urandom_range(0, 31));
        default: d = CFG_DATA_W'($urandom_range(0, 3));
      endcase
      write_reg(REG_LEAD_OFFSET, d);
      case ($urandom_range(0, 5))
        0:       d = 5'd0;
        1:       d = 5'd1;
        2:       d = 5'd16;
        3:       d = CFG_DATA_W'($urandom_range(17, 31));
        default: d = CFG_DATA_W'($urandom_range(2, 4));
      endcase
      write_reg(REG_PILOT_STRIDE, d);
      case ($urandom_range(0, 3))
        0:       d = 5'd0;
        1:       d = 5'd31;
        default: d = CFG_DATA_W'($urandom_range(0, 5));
      endcase
      write_reg(REG_TAIL_COUNT, d);
      for (int i = 0; i < 11; i++) begin
        // hold off once mid phase until every owed result is in
        if (ph == 3 && i == 7) begin
          @(negedge clk);
          in_push <= 1'b0;
          while (pending_out.size() != 0) @(posedge clk);
        end
        send_item(rand_sample(), rand_sample(), ($urandom_range(0, 4) == 0));
      end
    end
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    rst_n           = 1'b0;
    in_push         = 1'b0;
    in_sample_re    = '0;
    in_sample_im    = '0;
    in_final_sample = 1'b0;
    out_pop         = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = REG_LEAD_OFFSET;
    cfg_data        = '0;
    mismatch_cnt    = 0;
    fail_cnt        = 0;
    pop_stall       = 0;
    idle_en         = 1'b1;
    // model state after reset
    lead_cfg   = LEAD_RESET;
    stride_cfg = STRIDE_RESET;
    tail_cfg   = TAIL_RESET;
    prv_re     = '0;
    prv_im     = '0;
    need_first = 1'b1;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_config();
    test_long_lead_tail();
    test_stride_limits();
    test_unused_index();
    test_random_blocks();

    // drain, and catch anything stray before the verdict
    idle_en = 1'b0;
    settle();
    if (fail_cnt == 0 && pending_out.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### pilot_linear_interpolator_top.f
hw/rtl/pli_pkg.sv
hw/rtl/pli_front.sv
hw/rtl/pli_cmd_queue.sv
hw/rtl/pli_back.sv
hw/rtl/pilot_linear_interpolator_top.sv
tb/tb_top.sv
